### rtl/sha1_hash_engine_assert.svh
// Assertion macros used by the SHA-1 engine top level.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Implication checked in the same cycle.
`define SHA1_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 engine.
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned IDX_W        = 3;
   localparam int unsigned ROUND_W      = 7;
   localparam int unsigned FILL_W       = 6;
   localparam int unsigned BLOCK_W      = 512;
   localparam int unsigned LEN_W        = 64;
   localparam int unsigned BLKCNT_W     = LEN_W - 9;

   localparam logic [ROUND_W-1:0] LAST_ROUND    = 7'd79;
   localparam logic [ROUND_W-1:0] SCHED_ROUNDS  = 7'd16;
   localparam logic [IDX_W-1:0]   LAST_IDX      = 3'(DIGEST_WORDS - 1);
   localparam logic [FILL_W-1:0]  FILL_LAST     = 6'd63;
   localparam logic [FILL_W-1:0]  FILL_PAD_END  = 6'd55;
   localparam logic [7:0]         PAD_BYTE      = 8'h80;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_0 = 32'h5A827999;
   localparam word_type K_1 = 32'h6ED9EBA1;
   localparam word_type K_2 = 32'h8F1BBCDC;
   localparam word_type K_3 = 32'hCA62C1D6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADDH,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } sha1_state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD80,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic                shift_byte;
      byte_sel_type        byte_sel;
      logic                latch_len;
      logic                load_work;
      logic                round_en;
      logic [ROUND_W-1:0]  round_idx;
      logic                add_hash;
      logic                init;
      logic [IDX_W-1:0]    word_sel;
   } sha1_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_pad_end;
   } sha1_status_type;

   function automatic word_type round_f(input logic [ROUND_W-1:0] round,
                                        input word_type b, input word_type c,
                                        input word_type d);
      word_type f;
      if (round < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (round < 7'd40) begin
         f = b ^ c ^ d;
      end else if (round < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(input logic [ROUND_W-1:0] round);
      word_type k;
      if (round < 7'd20) begin
         k = K_0;
      end else if (round < 7'd40) begin
         k = K_1;
      end else if (round < 7'd60) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

endpackage

### rtl/sha1_hash_engine.sv
// Top level of the streaming SHA-1 engine: controller plus datapath.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | data_byte, byte_present, end_of_message
//   rsp     | out | rsp_valid/rsp_ready  | digest_word, word_index, last_word
//
// A byte that does not complete a block leaves the engine idle; it is ready again
// in the next cycle. The 64th byte of a block starts a compression, one round per
// cycle in a single round unit, then a step that adds the working words into the
// chaining value. An end of message pads one byte per cycle up to byte 56, shifts
// in eight length bytes and compresses again; a block with 56 or more bytes left
// needs a second padded block. The five digest words then leave one per accepted
// item. Reset is synchronous and needs no clearing pass. Input is held off during
// compression, padding and output, and the output words wait on rsp_ready.
`timescale 1ns / 1ps

`include "sha1_hash_engine_assert.svh"

module sha1_hash_engine import sha1_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_byte_present,
   input  logic             req_end_of_message,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [IDX_W-1:0] rsp_word_index,
   output logic             rsp_last_word
);

   sha1_cmd_type    cmd;
   sha1_status_type status;

   // The controller owns all sequencing; the datapath only follows commands.
   sha1_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .req_ready          (req_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .status             (status),
      .cmd                (cmd)
   );

   // The digest word is read straight from the chaining value registers, which
   // hold still while a word waits to be taken.
   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

   // Input and output are never open at the same time.
   `SHA1_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready, "input open during output")

   // An item that ends a message closes the input in the next cycle.
   `SHA1_ASSERT_NEXT(a_end_closes, clock, reset, req_valid && req_ready && req_end_of_message, !req_ready, "input open after end")

   // Words leave in order, with no gap between the index steps.
   `SHA1_ASSERT_NEXT(a_word_order, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest word out of order")

   // After the last word the engine is idle and takes input again.
   `SHA1_ASSERT_NEXT(a_back_idle, clock, reset, rsp_valid && rsp_ready && rsp_last_word, req_ready && !rsp_valid, "not idle after digest")

endmodule

### rtl/sha1_dp.sv
// SHA-1 datapath: block window, message schedule, round logic and chaining value.
`timescale 1ns / 1ps

module sha1_dp import sha1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sha1_cmd_type    cmd,
   input  logic [7:0]      data_byte,
   output sha1_status_type status,
   output word_type        digest_word
);

   logic [BLOCK_W-1:0]  window_ff, window_in;
   word_type            a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type            a_in, b_in, c_in, d_in, e_in;
   word_type            hash_ff [DIGEST_WORDS];
   word_type            hash_in [DIGEST_WORDS];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [BLKCNT_W-1:0] blocks_ff, blocks_in;
   logic [LEN_W-1:0]    len_ff, len_in;

   logic [7:0] shift_val;
   word_type   w0, w2, w8, w13, w_mix, w_new, w_t, temp;

   // Byte that enters the window this cycle.
   always_comb begin
      case (cmd.byte_sel)
         SEL_DATA:  shift_val = data_byte;
         SEL_PAD80: shift_val = PAD_BYTE;
         SEL_ZERO:  shift_val = 8'h00;
         SEL_LEN:   shift_val = len_ff[LEN_W-1 -: 8];
         default:   shift_val = 8'h00;
      endcase
   end

   // The window holds sixteen schedule words, the oldest at the top.
   assign w0    = window_ff[BLOCK_W-1 -: WORD_W];
   assign w2    = window_ff[BLOCK_W-1-2*WORD_W -: WORD_W];
   assign w8    = window_ff[BLOCK_W-1-8*WORD_W -: WORD_W];
   assign w13   = window_ff[BLOCK_W-1-13*WORD_W -: WORD_W];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
   assign w_t   = (cmd.round_idx < SCHED_ROUNDS) ? w0 : w_new;

   assign temp = {a_ff[WORD_W-6:0], a_ff[WORD_W-1 -: 5]}
               + round_f(cmd.round_idx, b_ff, c_ff, d_ff)
               + e_ff + round_k(cmd.round_idx) + w_t;

   always_comb begin
      window_in = window_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      hash_in = hash_ff;
      fill_in = fill_ff;
      blocks_in = blocks_ff;
      len_in = len_ff;

      if (cmd.shift_byte) begin
         window_in = {window_ff[BLOCK_W-9:0], shift_val};
         fill_in = fill_ff + 1'b1;
      end else if (cmd.round_en) begin
         window_in = {window_ff[BLOCK_W-WORD_W-1:0], w_t};
      end

      if (cmd.load_work) begin
         a_in = hash_ff[0];
         b_in = hash_ff[1];
         c_in = hash_ff[2];
         d_in = hash_ff[3];
         e_in = hash_ff[4];
      end else if (cmd.round_en) begin
         a_in = temp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[WORD_W-1:2]};
         d_in = c_ff;
         e_in = d_ff;
      end

      // Block count sits above the nine low bits: the fill in bytes, then three zero bits.
      if (cmd.latch_len) begin
         len_in = {blocks_ff, fill_ff, 3'b000};
      end else if (cmd.shift_byte && (cmd.byte_sel == SEL_LEN)) begin
         len_in = {len_ff[LEN_W-9:0], 8'h00};
      end

      if (cmd.add_hash) begin
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
         blocks_in = blocks_ff + 1'b1;
      end

      if (cmd.init) begin
         hash_in = H_INIT;
         fill_in = '0;
         blocks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= H_INIT;
         fill_ff <= '0;
         blocks_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         blocks_ff <= blocks_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      len_ff <= len_in;
   end

   assign status.fill_last    = (fill_ff == FILL_LAST);
   assign status.fill_pad_end = (fill_ff == FILL_PAD_END);
   assign digest_word         = hash_ff[cmd.word_sel];

endmodule

### rtl/sha1_ctrl.sv
// SHA-1 controller: state machine that sequences bytes, rounds, padding and output.
`timescale 1ns / 1ps

module sha1_ctrl import sha1_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_byte_present,
   input  logic             req_end_of_message,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IDX_W-1:0] rsp_word_index,
   output logic             rsp_last_word,
   input  sha1_status_type  status,
   output sha1_cmd_type     cmd
);

   sha1_state_type     state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               pad_ff, pad_in;
   logic               pad_first_ff, pad_first_in;
   logic               final_ff, final_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      round_in = '0;
      idx_in = idx_ff;
      pad_in = pad_ff;
      pad_first_in = pad_first_ff;
      final_in = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pad_in = req_end_of_message;
               pad_first_in = req_end_of_message;
               if (req_byte_present && status.fill_last) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADDH;
            end
         end
         ST_ADDH: begin
            if (final_ff) begin
               state_in = ST_OUT;
               idx_in = '0;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            pad_first_in = 1'b0;
            if (status.fill_last) begin
               state_in = ST_ROUND;
            end else if (status.fill_pad_end) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (status.fill_last) begin
               state_in = ST_ROUND;
               final_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
                  pad_in = 1'b0;
                  final_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.byte_sel = SEL_DATA;
      cmd.round_idx = round_ff;
      cmd.word_sel = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.shift_byte = req_valid && req_byte_present;
            cmd.load_work = req_valid && req_byte_present && status.fill_last;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         ST_ADDH: begin
            cmd.add_hash = 1'b1;
         end
         ST_PAD: begin
            cmd.shift_byte = 1'b1;
            cmd.byte_sel = pad_first_ff ? SEL_PAD80 : SEL_ZERO;
            cmd.latch_len = pad_first_ff;
            cmd.load_work = status.fill_last;
         end
         ST_LEN: begin
            cmd.shift_byte = 1'b1;
            cmd.byte_sel = SEL_LEN;
            cmd.load_work = status.fill_last;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.init = rsp_ready && (idx_ff == LAST_IDX);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         idx_ff <= '0;
         pad_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff <= idx_in;
         pad_ff <= pad_in;
         pad_first_ff <= pad_first_in;
         final_ff <= final_in;
      end
   end

endmodule

### sim/tb_sha1_hash_engine.sv
// Self-checking testbench for the streaming SHA-1 engine, with its own digest predictor.
`timescale 1ns / 1ps

module tb_sha1_hash_engine;
   import sha1_pkg::*;

   // The clock toggles every 5 ns. Reset is held high at the start, then released.
   logic             clock = 1'b0;
   logic             reset = 1'b1;

   // All block inputs start at known values, before reset is released.
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_data_byte = 8'h00;
   logic             req_byte_present = 1'b0;
   logic             req_end_of_message = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [31:0]      rsp_digest_word;
   logic [IDX_W-1:0] rsp_word_index;
   logic             rsp_last_word;

   always #5 clock = ~clock;

   sha1_hash_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   // One input item as the driver presents it.
   typedef struct {
      logic [7:0] data;
      logic       present;
      logic       eom;
   } byte_item_type;

   // One digest word as the engine should deliver it.
   typedef struct {
      logic [31:0]      word;
      logic [IDX_W-1:0] idx;
      logic             last;
   } digest_word_type;

   // Block fills that sit next to the padding decision: 55 bytes still leave room
   // for the length in the same block, 56 to 63 force a second padded block, and
   // 64 completes a block so that the padding starts in an empty one.
   localparam int BOUNDARY_LENS [6] = '{55, 56, 57, 63, 64, 65};

   // The tail wait is well above the time that two padded compressions take.
   localparam int DRAIN_CYCLES = 400;

   byte_item_type   pending_items [$];
   digest_word_type digest_q [$];

   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  fail_count     = 0;

   // ------------------------------------------------------------------
   // Digest predictor. It keeps its own chaining value, block bytes, fill
   // level and bit count, and turns every accepted item into the digest
   // words that it must cause.
   // ------------------------------------------------------------------
   logic [31:0] chain_h [DIGEST_WORDS];
   logic [7:0]  blk_bytes [64];
   int unsigned blk_fill;
   logic [63:0] bit_count;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         chain_h[i] = H_INIT[i];
      end
      blk_fill  = 0;
      bit_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
         sched[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
      end
      for (int r = 16; r < 80; r++) begin
         sched[r] = rol32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
         end else begin
            f = b ^ c ^ d;
            k = K_3;
         end
         t = rol32(a, 5) + f + e + k + sched[r];
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void predict_digest(input byte_item_type it);
      int unsigned     pos;
      logic [63:0]     total_bits;
      digest_word_type dw;
      // A byte is absorbed before any end of message in the same item, so it can
      // complete a block that is compressed ahead of the padding.
      if (it.present) begin
         blk_bytes[blk_fill] = it.data;
         blk_fill++;
         if (blk_fill == 64) begin
            compress_block();
            blk_fill  = 0;
            bit_count += 64'd512;
         end
      end
      if (it.eom) begin
         pos        = blk_fill;
         total_bits = bit_count + 64'(pos) * 64'd8;
         blk_bytes[pos] = PAD_BYTE;
         pos++;
         // No room left for the length: zero out this block and use another one.
         if (pos > 56) begin
            while (pos < 64) begin
               blk_bytes[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            blk_bytes[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            blk_bytes[56+i] = total_bits[63-8*i -: 8];
         end
         compress_block();
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            dw.word = chain_h[i];
            dw.idx  = IDX_W'(i);
            dw.last = (IDX_W'(i) == LAST_IDX);
            digest_q.push_back(dw);
         end
         restart_hash();
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver. A new item may be presented whenever the request slot is empty
   // or its item is accepted at this edge; otherwise valid and payload hold.
   // Each accepted item goes through the predictor at the edge it is taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      byte_item_type cur;
      byte_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.data    = req_data_byte;
            cur.present = req_byte_present;
            cur.eom     = req_end_of_message;
            predict_digest(cur);
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_items.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= nxt.data;
               req_byte_present   <= nxt.present;
               req_end_of_message <= nxt.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Every accepted digest word is checked field by field against
   // the oldest expected word. The ready line stalls at the phase's rate.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      digest_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected digest item: digest_word %h word_index %0d last_word %0b",
                      rsp_digest_word, rsp_word_index, rsp_last_word);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_digest_word !== want.word) begin
                  $error("digest_word: expected %h, got %h", want.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== want.idx) begin
                  $error("word_index: expected %0d, got %0d", want.idx, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== want.last) begin
                  $error("last_word: expected %0b, got %0b", want.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus generation.
   // ------------------------------------------------------------------
   task automatic push_item(input logic [7:0] data, input logic present, input logic eom);
      byte_item_type it;
      it.data    = data;
      it.present = present;
      it.eom     = eom;
      pending_items.push_back(it);
   endtask

   // Queues one message of msg_len random bytes with some empty items mixed in.
   // With end_with_byte set, the last byte carries the end of message itself;
   // otherwise a separate item without a byte ends it.
   task automatic add_message(input int msg_len, input bit end_with_byte, inout int count);
      for (int i = 0; i < msg_len; i++) begin
         if ($urandom_range(9) == 0) begin
            push_item(8'($urandom), 1'b0, 1'b0);
         end
         push_item(8'($urandom_range(255)), 1'b1, end_with_byte && (i == msg_len - 1));
         count++;
      end
      if (!end_with_byte || msg_len == 0) begin
         push_item(8'($urandom), 1'b0, 1'b1);
         count++;
      end
   endtask

   // Blocks until the driver has sent everything and every digest word has arrived.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_valid || digest_q.size() != 0);
   endtask

   int unsigned send_pcts [4] = '{0, 56, 0, 37};
   int unsigned recv_pcts [4] = '{0, 0, 56, 37};
   int          phase_targets [4] = '{120, 25, 25, 25};

   initial begin : stimulus
      int count;
      int sel;
      int msg_len;
      restart_hash();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items: the empty message, an item that carries nothing, a single
      // byte ending in the same item, byte extremes, and a short known string.
      push_item(8'hFF, 1'b0, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h55, 1'b0, 1'b1);
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h63, 1'b1, 1'b0);
      push_item(8'hAA, 1'b0, 1'b1);

      // Four idle profiles. Between them the sender holds off until every
      // expected digest word has come back, so each phase starts from idle.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_pcts[ph];
         recv_stall_pct = recv_pcts[ph];
         count = 0;
         if (ph == 0) begin
            // A 56-byte message needs the extra padded block, and a 64-byte one
            // whose last byte ends it fills a block in the same item.
            add_message(56, 1'b0, count);
            add_message(64, 1'b1, count);
         end
         while (count < phase_targets[ph]) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
               msg_len = $urandom_range(12);
            end else if (sel < 85) begin
               msg_len = BOUNDARY_LENS[$urandom_range(5)];
            end else begin
               msg_len = $urandom_range(130, 13);
            end
            add_message(msg_len, bit'($urandom_range(1)), count);
            if ($urandom_range(3) == 0) begin
               push_item(8'($urandom), 1'b0, 1'b0);
            end
         end
         wait_drained();
      end

      // Let any late, unexpected output surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (digest_q.size() != 0) begin
         $error("%0d expected digest words never arrived", digest_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
